>>> rtl/hne_pkg.sv
// Shared constants, types and helpers for the heightmap normal and height engine.
package hne_pkg;

  // Store geometry: address is {row, column}
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_LENGTH = 256;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Z_W        = $clog2(MAX_LENGTH);
  localparam int ADDR_W     = X_W + Z_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_LENGTH;
  localparam int DIM_W      = 9;

  // Unit normal width and one in Q1.11
  localparam int K_W = 12;
  localparam logic [K_W-1:0] K_ONE = 12'd2048;

  // Divider and square root step counts
  localparam int QUO_W    = 22;
  localparam int SQRT_STP = 11;

  // Command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_NORMAL = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_LENGTH = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_N_CENTER, ST_N_FETCH, ST_N_FACE,
    ST_F_SEL, ST_F_SQP, ST_F_SQQ, ST_F_N,
    ST_C_SQ, ST_C_START, ST_C_WAIT, ST_N_FIN,
    ST_Q_PREP, ST_Q_FETCH, ST_Q_M1, ST_Q_M2, ST_Q_SUM, ST_Q_FIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    U_IDLE, U_DIV, U_SQRT, U_DONE
  } unit_state_t;

  // Saturate a written dimension to 2..hi
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < 9'd2) begin
      r = 9'd2;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/hne_unit.sv
// Shared unit: one unit normal component, floor(sqrt(floor(m2 * 2^22 / n))).
module hne_unit import hne_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      m2,
  input  logic [33:0]      n,
  output logic             done,
  output logic [K_W-1:0]   k
);

  unit_state_t state, state_next;
  logic [33:0] nreg;
  logic [33:0] rem;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] quo_next;
  logic [34:0] rem2;
  logic        take;
  logic [QUO_W-1:0] v;
  logic [22:0] res;
  logic [22:0] bitw;
  logic [22:0] trial;
  logic [4:0]  cnt;

  // One restoring division step
  assign rem2     = {rem, 1'b0};
  assign take     = rem2 >= {1'b0, nreg};
  assign quo_next = {quo[QUO_W-2:0], take};
  assign trial    = res + bitw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      U_IDLE: begin
        if (start) begin
          state_next = ({2'b00, m2} == n) ? U_DONE : U_DIV;
        end
      end
      U_DIV: begin
        if (cnt == 5'd0) state_next = U_SQRT;
      end
      U_SQRT: begin
        if (cnt == 5'd0) state_next = U_DONE;
      end
      U_DONE: begin
        done       = 1'b1;
        state_next = U_IDLE;
      end
      default: state_next = U_IDLE;
    endcase
  end

  // Datapath: divide, then take the integer root one digit a step
  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        nreg <= n;
        rem  <= {2'b00, m2};
        quo  <= '0;
        cnt  <= 5'(QUO_W - 1);
        res  <= {11'd0, K_ONE};
      end
      U_DIV: begin
        rem <= take ? 34'(rem2 - {1'b0, nreg}) : rem2[33:0];
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          v    <= quo_next;
          res  <= '0;
          bitw <= 23'd1 << 20;
          cnt  <= 5'(SQRT_STP - 1);
        end
      end
      U_SQRT: begin
        if ({1'b0, v} >= trial) begin
          v   <= QUO_W'({1'b0, v} - trial);
          res <= (res >> 1) + bitw;
        end else begin
          res <= res >> 1;
        end
        bitw <= bitw >> 2;
        cnt  <= cnt - 5'd1;
      end
      default: begin
      end
    endcase
  end

  assign k = res[K_W-1:0];

endmodule

>>> rtl/heightmap_normal_and_height_engine.sv
// Top level: heightmap store, smoothed normal sequencer and height interpolation.
//
//  channel   direction  handshake          payload
//  s_*       in         tvalid / tready    tuser command, tdata grid and query fields
//  m_*       out        tvalid / tready    tdata normals and height
//  cfg_*     in         valid / ready      index, 9-bit data
//
// After reset the store is swept to zero, one entry a cycle, over all 65536 entries with
// s_tready low; the configuration port is always ready.
// A height write is done as it is accepted. A height query makes four reads
// of the single read port and two passes through the multiplier. A normal read
// covers up to 5 points x 4 faces x 3 components, each component passing
// through the shared divide and square root unit.
// One item is in work at a time; a finished result waits in the output register.
module heightmap_normal_and_height_engine import hne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // command
  input  logic [63:0] s_tdata,   // grid_x, grid_z, height_value, query_x, query_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // normal_x, normal_y, normal_z, height_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  state_t state, state_next;

  // Configuration
  logic [DIM_W-1:0] gw, gl;
  logic [X_W-1:0]   gw_m1;
  logic [Z_W-1:0]   gl_m1;

  // Input fields
  logic [X_W-1:0] in_gx;
  logic [Z_W-1:0] in_gz;
  logic [15:0]    in_hv, in_qx, in_qz;
  logic           in_acc;

  // Store
  logic [15:0]       mem [0:DEPTH-1];
  logic [15:0]       rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] clr_cnt;

  // Sequencer
  logic [2:0]     ci, fc, f;
  logic [1:0]     j;
  logic [X_W-1:0] cx_r, px, cen_x;
  logic [Z_W-1:0] cz_r, pz, cen_z;
  logic           cen_en;
  logic signed [15:0] hs [0:4];

  // Face arithmetic
  logic lo_x, hi_x, lo_z, hi_z;
  logic signed [17:0] da, db, dc, de, fp, fq, p_reg, q_reg, cval;
  logic [3:0]  face_en;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic [33:0] nsum;
  logic signed [17:0] sx, sy, sz, term;
  logic signed [17:0] hx, hy, hz;

  // Shared unit
  logic           u_start, u_done;
  logic [K_W-1:0] u_k;

  // Query
  logic [15:0]    qx_r, qz_r, mx, mz;
  logic [X_W-1:0] qcx, qcx_c;
  logic [Z_W-1:0] qcz, qcz_c;
  logic [8:0]     fx, fz;
  logic           upper;
  logic signed [17:0] d1, d2;
  logic [8:0]     g1, g2;
  logic signed [15:0] qbase;
  logic signed [27:0] qacc;
  logic signed [27:0] qrnd;
  logic signed [19:0] qr;

  // Result
  logic [15:0] res_nx, res_ny, res_nz, res_h;

  assign gw_m1 = X_W'(gw - 9'd1);
  assign gl_m1 = Z_W'(gl - 9'd1);
  assign in_gx = s_tdata[7:0];
  assign in_gz = s_tdata[15:8];
  assign in_hv = s_tdata[31:16];
  assign in_qx = s_tdata[47:32];
  assign in_qz = s_tdata[63:48];
  assign in_acc = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes, saturated to the legal range
  always_ff @(posedge clk) begin
    if (rst) begin
      gw <= 9'(MAX_WIDTH);
      gl <= 9'(MAX_LENGTH);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:  gw <= clamp_dim(cfg_data, 9'(MAX_WIDTH));
        REG_GRID_LENGTH: gl <= clamp_dim(cfg_data, 9'(MAX_LENGTH));
        default: begin
        end
      endcase
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // Select the centre point of the current rough normal
  always_comb begin
    cen_en = 1'b0;
    cen_x  = cx_r;
    cen_z  = cz_r;
    case (ci)
      3'd0: cen_en = 1'b1;
      3'd1: begin cen_en = cx_r != '0;    cen_x = cx_r - 1'b1; end
      3'd2: begin cen_en = cx_r != gw_m1; cen_x = cx_r + 1'b1; end
      3'd3: begin cen_en = cz_r != '0;    cen_z = cz_r - 1'b1; end
      3'd4: begin cen_en = cz_r != gl_m1; cen_z = cz_r + 1'b1; end
      default: cen_en = 1'b0;
    endcase
  end

  // Height differences around the point and the four quadrant faces
  assign lo_x = px != '0;
  assign hi_x = px < gw_m1;
  assign lo_z = pz != '0;
  assign hi_z = pz < gl_m1;
  assign da = lo_z ? 18'(hs[1]) - 18'(hs[0]) : 18'sd0;
  assign dc = hi_z ? 18'(hs[2]) - 18'(hs[0]) : 18'sd0;
  assign db = lo_x ? 18'(hs[3]) - 18'(hs[0]) : 18'sd0;
  assign de = hi_x ? 18'(hs[4]) - 18'(hs[0]) : 18'sd0;
  assign face_en = {hi_x && lo_z, hi_x && hi_z, lo_x && hi_z, lo_x && lo_z};

  always_comb begin
    case (f)
      3'd0:    begin fp = db;  fq = da;  end
      3'd1:    begin fp = db;  fq = -dc; end
      3'd2:    begin fp = -de; fq = -dc; end
      default: begin fp = -de; fq = da;  end
    endcase
  end

  always_comb begin
    case (j)
      2'd0:    cval = p_reg;
      2'd1:    cval = 18'sd256;
      default: cval = q_reg;
    endcase
  end

  // Signed, weighted unit component
  always_comb begin
    term = cval < 0 ? -18'(u_k) : 18'(u_k);
    if (ci == 3'd0) term = term <<< 1;
  end

  // Query cell and triangle selection
  assign mx    = {gw_m1, 8'h00};
  assign mz    = {gl_m1, 8'h00};
  assign qcx_c = (qx_r[15:8] == gw_m1) ? qx_r[15:8] - 1'b1 : qx_r[15:8];
  assign qcz_c = (qz_r[15:8] == gl_m1) ? qz_r[15:8] - 1'b1 : qz_r[15:8];
  assign upper = (10'(fx) + 10'(fz)) > 10'd256;
  assign d1    = upper ? 18'(hs[2]) - 18'(hs[3]) : 18'(hs[1]) - 18'(hs[0]);
  assign d2    = upper ? 18'(hs[1]) - 18'(hs[3]) : 18'(hs[2]) - 18'(hs[0]);
  assign g1    = upper ? 9'(9'd256 - fx) : fx;
  assign g2    = upper ? 9'(9'd256 - fz) : fz;
  assign qbase = upper ? hs[3] : hs[0];
  assign qrnd  = qacc + 28'sd128;
  assign qr    = 20'(qrnd >>> 8);

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  hne_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .m2    (prod[31:0]),
    .n     (nsum),
    .done  (u_done),
    .k     (u_k)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt;
    mem_wdata  = '0;
    mem_raddr  = '0;
    mul_a      = '0;
    mul_b      = '0;
    u_start    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready  = 1'b1;
        mem_waddr = {in_gz, in_gx};
        mem_wdata = in_hv;
        if (in_acc) begin
          case (s_tuser)
            CMD_WRITE:  mem_we = 1'b1;
            CMD_NORMAL: state_next = ST_N_CENTER;
            CMD_QUERY:  state_next = ST_Q_PREP;
            default: begin
            end
          endcase
        end
      end
      ST_N_CENTER: begin
        if (ci == 3'd5) begin
          state_next = ST_N_FIN;
        end else if (cen_en) begin
          state_next = ST_N_FETCH;
        end
      end
      ST_N_FETCH: begin
        case (fc)
          3'd0:    mem_raddr = {pz, px};
          3'd1:    mem_raddr = {pz - 1'b1, px};
          3'd2:    mem_raddr = {pz + 1'b1, px};
          3'd3:    mem_raddr = {pz, px - 1'b1};
          default: mem_raddr = {pz, px + 1'b1};
        endcase
        if (fc == 3'd5) state_next = ST_N_FACE;
      end
      ST_N_FACE: begin
        if (f == 3'd4) begin
          state_next = ST_N_CENTER;
        end else if (face_en[f[1:0]]) begin
          state_next = ST_F_SEL;
        end
      end
      ST_F_SEL: state_next = ST_F_SQP;
      ST_F_SQP: begin
        mul_a = p_reg;
        mul_b = p_reg;
        state_next = ST_F_SQQ;
      end
      ST_F_SQQ: begin
        mul_a = q_reg;
        mul_b = q_reg;
        state_next = ST_F_N;
      end
      ST_F_N: state_next = ST_C_SQ;
      ST_C_SQ: begin
        mul_a = cval;
        mul_b = cval;
        state_next = ST_C_START;
      end
      ST_C_START: begin
        u_start = 1'b1;
        state_next = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (u_done) state_next = (j == 2'd2) ? ST_N_FACE : ST_C_SQ;
      end
      ST_N_FIN: state_next = ST_DONE;
      ST_Q_PREP: state_next = ST_Q_FETCH;
      ST_Q_FETCH: begin
        case (fc)
          3'd0:    mem_raddr = {qcz, qcx};
          3'd1:    mem_raddr = {qcz, qcx + 1'b1};
          3'd2:    mem_raddr = {qcz + 1'b1, qcx};
          default: mem_raddr = {qcz + 1'b1, qcx + 1'b1};
        endcase
        if (fc == 3'd4) state_next = ST_Q_M1;
      end
      ST_Q_M1: begin
        mul_a = d1;
        mul_b = {9'd0, g1};
        state_next = ST_Q_M2;
      end
      ST_Q_M2: begin
        mul_a = d2;
        mul_b = {9'd0, g2};
        state_next = ST_Q_SUM;
      end
      ST_Q_SUM: state_next = ST_Q_FIN;
      ST_Q_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer counters and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          cx_r <= (in_gx > gw_m1) ? gw_m1 : in_gx;
          cz_r <= (in_gz > gl_m1) ? gl_m1 : in_gz;
          qx_r <= (in_qx > mx) ? mx : in_qx;
          qz_r <= (in_qz > mz) ? mz : in_qz;
          ci   <= '0;
          sx   <= '0;
          sy   <= '0;
          sz   <= '0;
        end
        ST_N_CENTER: begin
          px <= cen_x;
          pz <= cen_z;
          fc <= '0;
          f  <= '0;
          if (!cen_en && ci != 3'd5) ci <= ci + 1'b1;
        end
        ST_N_FETCH, ST_Q_FETCH: begin
          if (fc != 3'd0) hs[fc - 1'b1] <= rdata;
          fc <= fc + 1'b1;
        end
        ST_N_FACE: begin
          if (f == 3'd4) begin
            ci <= ci + 1'b1;
          end else if (!face_en[f[1:0]]) begin
            f <= f + 1'b1;
          end
        end
        ST_F_SEL: begin
          p_reg <= fp;
          q_reg <= fq;
          j     <= '0;
        end
        ST_F_SQQ: nsum <= 34'(prod[32:0]) + 34'd65536;
        ST_F_N:   nsum <= nsum + 34'(prod[32:0]);
        ST_C_WAIT: begin
          if (u_done) begin
            case (j)
              2'd0:    sx <= sx + term;
              2'd1:    sy <= sy + term;
              default: sz <= sz + term;
            endcase
            if (j == 2'd2) begin
              f <= f + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        ST_N_FIN: begin
          res_nx <= hx[15:0];
          res_ny <= (hx == 0 && hy == 0 && hz == 0) ? 16'd2048 : hy[15:0];
          res_nz <= hz[15:0];
          res_h  <= '0;
        end
        ST_Q_PREP: begin
          qcx <= qcx_c;
          qcz <= qcz_c;
          fx  <= 9'(qx_r - {qcx_c, 8'h00});
          fz  <= 9'(qz_r - {qcz_c, 8'h00});
          fc  <= '0;
        end
        ST_Q_M2:  qacc <= {{4{qbase[15]}}, qbase, 8'h00} + 28'(prod);
        ST_Q_SUM: qacc <= qacc + 28'(prod);
        ST_Q_FIN: begin
          res_nx <= '0;
          res_ny <= '0;
          res_nz <= '0;
          if (qr > 20'sd32767) begin
            res_h <= 16'h7fff;
          end else if (qr < -20'sd32768) begin
            res_h <= 16'h8000;
          end else begin
            res_h <= qr[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Halve the weighted sums, rounding toward minus infinity
  assign hx = sx >>> 1;
  assign hy = sy >>> 1;
  assign hz = sz >>> 1;

  // Output register: load when free, drop on a completed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {res_h, res_nz, res_ny, res_nx};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
